// ===== rtl/rfp_pkg.sv =====
// Shared types and constants for the response frame parser.
package rfp_pkg;

	// Default store depth in data words.
	localparam int MAX_WORDS_DEF = 16;

	// Configuration port geometry and register reset values.
	localparam int CFG_W = 16;
	localparam logic [4:0] WORD_COUNT_RST = 5'd1;
	localparam logic [15:0] TIMEOUT_RST = 16'd4000;

	// Stream payload widths.
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 32;

	// Frame header bytes.
	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] DLE_BYTE = 8'h10;
	localparam logic [7:0] ETB_BYTE = 8'h17;
	localparam logic [23:0] HDR_PREFIX = {SYNC_BYTE, SYNC_BYTE, DLE_BYTE};
	localparam logic [7:0] ADD_SEED = DLE_BYTE + ETB_BYTE;
	localparam logic [7:0] XOR_SEED = DLE_BYTE ^ ETB_BYTE;
	localparam logic [15:0] TICK_MAX = 16'hFFFF;

	typedef enum logic [0:0] {
		REG_WORD_COUNT    = 1'b0,
		REG_FRAME_TIMEOUT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_ARM  = 2'd0,
		OP_BYTE = 2'd1,
		OP_TICK = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_HDR_TIMEOUT  = 3'd1,
		ST_BODY_TIMEOUT = 3'd2,
		ST_ADD_ERR      = 3'd3,
		ST_XOR_ERR      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_SEARCH = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	// End-of-run event from the frame engine to the result stage.
	typedef struct packed {
		logic    valid;
		logic    ok;
		status_t code;
	} finish_t;

endpackage

// ===== rtl/rfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rfp_core.sv =====
// Frame engine: header search, body collection, sums and timeouts.
module rfp_core import rfp_pkg::*; #(
	parameter int MAX_WORDS = MAX_WORDS_DEF,
	localparam int CNT_W = $clog2(MAX_WORDS + 1),
	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
	localparam int BC_W = $clog2(2 * MAX_WORDS + 6)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [1:0]       op,
	input  logic [7:0]       rx_byte,
	input  logic [4:0]       word_count,
	input  logic [15:0]      timeout,
	output finish_t          fin,
	output logic [15:0]      station,
	output logic [CNT_W-1:0] words,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output logic [7:0]       wr_data
);

	phase_t            phase_q, phase_d;
	logic [23:0]       window_q, window_d;
	logic [BC_W-1:0]   body_q, body_d;
	logic [7:0]        add_q, add_d;
	logic [7:0]        xor_q, xor_d;
	logic [7:0]        radd_q, radd_d;
	logic [15:0]       station_q, station_d;
	logic [15:0]       elapsed_q, elapsed_d;
	logic [CNT_W-1:0]  words_q, words_d;
	logic [BC_W-1:0]   dlen;
	logic [BC_W-1:0]   data_off;
	logic [15:0]       elapsed_inc;

	assign dlen = BC_W'({words_q, 1'b0});
	assign data_off = body_q - BC_W'(2);
	assign elapsed_inc = (elapsed_q != TICK_MAX) ? elapsed_q + 16'd1 : elapsed_q;

	// Next-state logic for one accepted transaction.
	always_comb begin
		phase_d = phase_q;
		window_d = window_q;
		body_d = body_q;
		add_d = add_q;
		xor_d = xor_q;
		radd_d = radd_q;
		station_d = station_q;
		elapsed_d = elapsed_q;
		words_d = words_q;
		fin = '0;
		fin.code = ST_OK;
		wr_en = 1'b0;
		wr_addr = data_off[AW:1];
		wr_data = rx_byte;
		if (fire) begin
			case (op)
				OP_ARM: begin
					if (word_count == '0) begin
						words_d = CNT_W'(1);
					end else if (int'(word_count) > MAX_WORDS) begin
						words_d = CNT_W'(MAX_WORDS);
					end else begin
						words_d = CNT_W'(word_count);
					end
					phase_d = PH_SEARCH;
					window_d = '0;
					body_d = '0;
					add_d = '0;
					xor_d = '0;
					radd_d = '0;
					elapsed_d = '0;
				end
				OP_TICK: begin
					if (phase_q != PH_IDLE) begin
						elapsed_d = elapsed_inc;
						if (elapsed_inc >= timeout) begin
							fin.valid = 1'b1;
							fin.code = (phase_q == PH_SEARCH) ? ST_HDR_TIMEOUT : ST_BODY_TIMEOUT;
							phase_d = PH_IDLE;
						end
					end
				end
				OP_BYTE: begin
					case (phase_q)
						PH_SEARCH: begin
							if (window_q == HDR_PREFIX && rx_byte == ETB_BYTE) begin
								phase_d = PH_BODY;
								body_d = '0;
								elapsed_d = '0;
								add_d = ADD_SEED;
								xor_d = XOR_SEED;
							end else begin
								window_d = {window_q[15:0], rx_byte};
							end
						end
						PH_BODY: begin
							body_d = body_q + BC_W'(1);
							if (body_q < dlen + BC_W'(2)) begin
								// Station and data bytes enter both sums.
								add_d = add_q + rx_byte;
								xor_d = xor_q ^ rx_byte;
								if (body_q == '0) begin
									station_d = {rx_byte, 8'h00};
								end else if (body_q == BC_W'(1)) begin
									station_d = {station_q[15:8], rx_byte};
								end else if (!body_q[0]) begin
									wr_en = 1'b1;
								end
							end else if (body_q < dlen + BC_W'(4)) begin
								// Status bytes are skipped.
								add_d = add_q;
							end else if (body_q == dlen + BC_W'(4)) begin
								radd_d = rx_byte;
							end else begin
								// XOR sum byte closes the frame.
								fin.valid = 1'b1;
								phase_d = PH_IDLE;
								if (radd_q != add_q) begin
									fin.code = ST_ADD_ERR;
								end else if (rx_byte != xor_q) begin
									fin.code = ST_XOR_ERR;
								end else begin
									fin.ok = 1'b1;
								end
							end
						end
						default: begin
							phase_d = phase_q;
						end
					endcase
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			window_q <= '0;
			body_q <= '0;
			add_q <= '0;
			xor_q <= '0;
			radd_q <= '0;
			station_q <= '0;
			elapsed_q <= '0;
			words_q <= CNT_W'(1);
		end else begin
			phase_q <= phase_d;
			window_q <= window_d;
			body_q <= body_d;
			add_q <= add_d;
			xor_q <= xor_d;
			radd_q <= radd_d;
			station_q <= station_d;
			elapsed_q <= elapsed_d;
			words_q <= words_d;
		end
	end

	assign station = station_q;
	assign words = words_q;

endmodule

// ===== rtl/rfp_emit.sv =====
// Result stage: output register and read-out of stored data words.
module rfp_emit import rfp_pkg::*; #(
	parameter int MAX_WORDS = MAX_WORDS_DEF,
	localparam int CNT_W = $clog2(MAX_WORDS + 1),
	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  finish_t             fin,
	input  logic [CNT_W-1:0]    words,
	input  logic [15:0]         station,
	input  logic [7:0]          rd_data,
	output logic [AW-1:0]       rd_addr,
	output logic                busy,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser,
	output logic                m_tlast
);

	logic             drain_q, drain_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic             out_valid_q;
	logic             out_status_q;
	logic [7:0]       out_byte_q;
	logic [15:0]      out_station_q;
	status_t          out_code_q;
	logic             out_free;
	logic             load;
	logic             ld_status;
	logic [7:0]       ld_byte;
	status_t          ld_code;

	assign out_free = !out_valid_q || m_tready;

	// Pick the next result: a stored word, the closing status or an error status.
	always_comb begin
		drain_d = drain_q;
		idx_d = idx_q;
		load = 1'b0;
		ld_status = 1'b1;
		ld_byte = '0;
		ld_code = ST_OK;
		if (drain_q) begin
			if (out_free) begin
				load = 1'b1;
				if (idx_q < words) begin
					ld_status = 1'b0;
					ld_byte = rd_data;
					idx_d = idx_q + CNT_W'(1);
				end else begin
					drain_d = 1'b0;
				end
			end
		end else if (fin.valid) begin
			if (fin.ok) begin
				drain_d = 1'b1;
				idx_d = '0;
			end else begin
				load = 1'b1;
				ld_code = fin.code;
			end
		end
	end

	// The read address runs one step ahead so the data lines up with idx_q.
	assign rd_addr = idx_d[AW-1:0];
	assign busy = drain_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			drain_q <= drain_d;
			idx_q <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= ld_status;
			out_byte_q <= ld_byte;
			out_station_q <= station;
			out_code_q <= ld_code;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_status_q;
	assign m_tlast = out_status_q;
	assign m_tdata = {5'b0, out_code_q, out_station_q, out_byte_q};

endmodule

// ===== rtl/response_frame_parser.sv =====
// Top level of the response frame parser.
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------------
//  s_*     | in        | tuser opcode[1:0]; tdata rx_byte[7:0]
//  m_*     | out       | tuser is_status; tlast last; tdata data_byte[7:0],
//          |           | station_id[23:8], status_code[26:24], zero[31:27]
//  cfg_*   | in        | index 0 word_count[4:0], index 1 frame_timeout_ticks[15:0]
//
// One input transaction is taken per cycle unless held off: it is registered,
// processed in one pass and its result registered. A good frame then reads its
// data words from the word RAM at one per cycle unless stalled, holding input off.
// Reset clears all control state and loads the register reset values.
// A stalled output holds its transaction and backs up into the input register.
module response_frame_parser import rfp_pkg::*; #(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // rx_byte[7:0]
	input  logic [1:0]          s_tuser,   // opcode[1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // data_byte, station_id, status_code, pad
	output logic                m_tuser,   // is_status
	output logic                m_tlast,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_idx,
	input  logic [CFG_W-1:0]    cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_WORDS + 1);
	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [7:0]       byte_s1;
	logic [4:0]       word_count_q;
	logic [15:0]      timeout_q;
	logic             fire;
	logic             busy;
	logic             out_free;
	finish_t          fin;
	logic [15:0]      station;
	logic [CNT_W-1:0] words;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [7:0]       wr_data;
	logic [AW-1:0]    rd_addr;
	logic [7:0]       rd_data;

	assign out_free = !m_tvalid || m_tready;
	assign fire = valid_s1 && !busy && out_free;
	assign s_tready = !valid_s1 || fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= WORD_COUNT_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WORD_COUNT: word_count_q <= cfg_wdata[4:0];
				REG_FRAME_TIMEOUT: timeout_q <= cfg_wdata[15:0];
				default: timeout_q <= timeout_q;
			endcase
		end
	end

	rfp_core #(.MAX_WORDS(MAX_WORDS)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.op         (op_s1),
		.rx_byte    (byte_s1),
		.word_count (word_count_q),
		.timeout    (timeout_q),
		.fin        (fin),
		.station    (station),
		.words      (words),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	rfp_ram #(.WIDTH(8), .DEPTH(MAX_WORDS)) u_words (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rfp_emit #(.MAX_WORDS(MAX_WORDS)) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.fin      (fin),
		.words    (words),
		.station  (station),
		.rd_data  (rd_data),
		.rd_addr  (rd_addr),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/rfp_checker.sv =====
// Port-level checks for the response frame parser and their binding.
module rfp_checker import rfp_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tuser,
	input logic                m_tlast
);

	// A stalled result transaction holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// Only the status item closes a run.
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tlast == m_tuser)
		else $error("tlast and status flag disagree");

	// Data items carry a zero status code.
	a_data_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[26:24] == ST_OK)
		else $error("data item with nonzero status");

	// Status items carry a zero data byte and a defined code.
	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] == 8'h00 && m_tdata[31:27] == 5'b0
			&& m_tdata[26:24] <= ST_XOR_ERR)
		else $error("malformed status item");

endmodule

bind response_frame_parser rfp_checker u_rfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
